### rtl/perjl_pkg.sv
package perjl_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [23:0] RTT_LIMIT_RESET = 24'd10000000;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_BEGIN  = 2'd1,
        OP_RESP   = 2'd2,
        OP_FINISH = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_NONE     = 3'd2,
        ST_NOMATCH  = 3'd3,
        ST_RANGE    = 3'd4,
        ST_COMPLETE = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RTT,
        S_SCAN,
        S_SCAN_CHK,
        S_FIN_DIV,
        S_COMPACT,
        S_COMPACT_CHK,
        S_OUT
    } state_t;

    typedef struct packed {
        logic            rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic            wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [31:0]     wr_seq;
        logic [31:0]     wr_dst;
    } mem_ctl_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;

endpackage

### rtl/perjl_table.sv
module perjl_table (
    input  logic                 aclk,
    input  perjl_pkg::mem_ctl_t  ctl,
    output logic [31:0]          rd_seq,
    output logic [31:0]          rd_dst
);
    import perjl_pkg::*;

    logic [63:0] mem [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[ctl.wr_addr] <= {ctl.wr_seq, ctl.wr_dst};
        end
        if (ctl.rd_en) begin
            {rd_seq, rd_dst} <= mem[ctl.rd_addr];
        end
    end
endmodule

### rtl/perjl_div.sv
module perjl_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  perjl_pkg::div_req_t req,
    output perjl_pkg::div_rsp_t rsp
);
    import perjl_pkg::*;

    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[63]} - {2'b00, den_reg};
        if (req.start) begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[33]) begin
                rem_next = trial[32:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = {rem_reg[31:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule

### rtl/perjl_ctrl.sv
module perjl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_opcode,
    input  logic [31:0]          s_seq_number,
    input  logic [31:0]          s_dest_addr,
    input  logic [31:0]          s_sent_sec,
    input  logic [19:0]          s_sent_usec,
    input  logic [31:0]          s_recv_sec,
    input  logic [19:0]          s_recv_usec,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status,
    output logic [23:0]          m_sample_rtt_us,
    output logic [23:0]          m_avg_rtt_us,
    output logic [23:0]          m_jitter_us,
    output logic [13:0]          m_loss_centipct,
    output logic [7:0]           m_received_count,
    output logic [7:0]           m_expected_count,
    input  logic [23:0]          rtt_limit,
    output perjl_pkg::mem_ctl_t  mem_ctl,
    input  logic [31:0]          rd_seq,
    input  logic [31:0]          rd_dst,
    output perjl_pkg::div_req_t  div_req,
    input  perjl_pkg::div_rsp_t  div_rsp
);
    import perjl_pkg::*;

    state_t state_reg, state_next;
    logic [1:0] phase_reg, phase_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0] target_reg, target_next;
    logic [CNT_W-1:0] expect_reg, expect_next;
    logic [CNT_W-1:0] accept_reg, accept_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] adiff_reg, adiff_next;
    logic [23:0] prev_rtt_reg, prev_rtt_next;

    logic [31:0] seq_reg, seq_next;
    logic [52:0] diff_sec_reg, diff_sec_next;
    logic [20:0] diff_usec_reg, diff_usec_next;
    logic [53:0] rtt_reg, rtt_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] wr_idx_reg, wr_idx_next;

    logic [2:0]  o_status_reg, o_status_next;
    logic [23:0] o_sample_reg, o_sample_next;
    logic [23:0] o_avg_reg, o_avg_next;
    logic [23:0] o_jit_reg, o_jit_next;
    logic [13:0] o_loss_reg, o_loss_next;

    logic [32:0] sum33;
    logic [23:0] absd;
    logic [63:0] q_sat;
    logic [CNT_W-1:0] lost;

    always_comb begin
        q_sat = (div_rsp.quo > 64'hFFFFFF) ? 64'hFFFFFF : div_rsp.quo;
        lost  = (expect_reg > accept_reg) ? expect_reg - accept_reg : '0;
        absd  = (rtt_reg[23:0] > prev_rtt_reg) ? rtt_reg[23:0] - prev_rtt_reg
                                               : prev_rtt_reg - rtt_reg[23:0];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    case (opcode_t'(s_opcode))
                        OP_RECORD: state_next = S_OUT;
                        OP_BEGIN:  state_next = S_OUT;
                        OP_RESP: begin
                            if (expect_reg == '0 || accept_reg >= expect_reg) begin
                                state_next = S_OUT;
                            end else begin
                                state_next = S_RTT;
                            end
                        end
                        default: state_next = S_FIN_DIV;
                    endcase
                end
            end
            S_RTT:      state_next = S_SCAN;
            S_SCAN: begin
                if (rd_idx_reg >= count_reg) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (rd_seq == seq_reg && rd_dst == target_reg) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_FIN_DIV: begin
                if (phase_reg == 2'd3 && div_rsp.done) begin
                    state_next = S_COMPACT;
                end
            end
            S_COMPACT: begin
                if (rd_idx_reg >= count_reg) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_COMPACT_CHK;
                end
            end
            S_COMPACT_CHK: state_next = S_COMPACT;
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        target_next    = target_reg;
        expect_next    = expect_reg;
        accept_next    = accept_reg;
        total_next     = total_reg;
        adiff_next     = adiff_reg;
        prev_rtt_next  = prev_rtt_reg;
        seq_next       = seq_reg;
        diff_sec_next  = diff_sec_reg;
        diff_usec_next = diff_usec_reg;
        rtt_next       = rtt_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        o_status_next  = o_status_reg;
        o_sample_next  = o_sample_reg;
        o_avg_next     = o_avg_reg;
        o_jit_next     = o_jit_reg;
        o_loss_next    = o_loss_reg;
        sum33          = '0;
        mem_ctl        = '0;
        div_req        = '0;
        case (state_reg)
            S_IDLE: begin
                seq_next      = s_seq_number;
                diff_sec_next = 53'($signed({1'b0, s_recv_sec}) - $signed({1'b0, s_sent_sec}))
                                * 53'd1000000;
                diff_usec_next = {1'b0, s_recv_usec} - {1'b0, s_sent_usec};
                rd_idx_next   = '0;
                wr_idx_next   = '0;
                phase_next    = 2'd0;
                o_status_next = ST_OK;
                o_sample_next = '0;
                o_avg_next    = '0;
                o_jit_next    = '0;
                o_loss_next   = '0;
                if (s_valid) begin
                    case (opcode_t'(s_opcode))
                        OP_RECORD: begin
                            if (count_reg < CNT_W'(TABLE_DEPTH)) begin
                                mem_ctl.wr_en   = 1'b1;
                                mem_ctl.wr_addr = count_reg[IDX_W-1:0];
                                mem_ctl.wr_seq  = s_seq_number;
                                mem_ctl.wr_dst  = s_dest_addr;
                                count_next      = count_reg + 1'b1;
                            end else begin
                                o_status_next = ST_FULL;
                            end
                        end
                        OP_BEGIN: begin
                            target_next   = s_dest_addr;
                            expect_next   = count_reg;
                            accept_next   = '0;
                            total_next    = '0;
                            adiff_next    = '0;
                            prev_rtt_next = '0;
                            if (count_reg == '0) begin
                                o_status_next = ST_NONE;
                            end
                        end
                        OP_RESP: begin
                            if (expect_reg == '0) begin
                                o_status_next = ST_NONE;
                            end else if (accept_reg >= expect_reg) begin
                                o_status_next = ST_COMPLETE;
                            end
                        end
                        default: begin
                            if (expect_reg == '0) begin
                                o_status_next = ST_NONE;
                            end
                        end
                    endcase
                end
            end
            S_RTT: begin
                rtt_next = 54'($signed(diff_sec_reg)) + 54'($signed(diff_usec_reg));
            end
            S_SCAN: begin
                if (rd_idx_reg >= count_reg) begin
                    o_status_next = ST_NOMATCH;
                end else begin
                    mem_ctl.rd_en   = 1'b1;
                    mem_ctl.rd_addr = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next     = rd_idx_reg + 1'b1;
                end
            end
            S_SCAN_CHK: begin
                if (rd_seq == seq_reg && rd_dst == target_reg) begin
                    if (rtt_reg[53] || rtt_reg >= {30'd0, rtt_limit}) begin
                        o_status_next = ST_RANGE;
                    end else begin
                        if (accept_reg != '0) begin
                            sum33      = {1'b0, adiff_reg} + {9'd0, absd};
                            adiff_next = sum33[32] ? 32'hFFFFFFFF : sum33[31:0];
                        end
                        total_next    = ({1'b0, total_reg} + {9'd0, rtt_reg[23:0]}) > 33'hFFFFFFFF
                                        ? 32'hFFFFFFFF : total_reg + {8'd0, rtt_reg[23:0]};
                        prev_rtt_next = rtt_reg[23:0];
                        accept_next   = accept_reg + 1'b1;
                        o_sample_next = rtt_reg[23:0];
                    end
                end
            end
            S_FIN_DIV: begin
                case (phase_reg)
                    2'd0: begin
                        o_loss_next = 14'd10000;
                        if (accept_reg != '0) begin
                            div_req.start = 1'b1;
                            div_req.num   = {32'd0, total_reg} + 64'(accept_reg >> 1);
                            div_req.den   = 32'(accept_reg);
                            phase_next    = 2'd1;
                        end else begin
                            phase_next = 2'd3;
                            div_req.start = 1'b1;
                            div_req.num   = '0;
                            div_req.den   = 32'd1;
                        end
                    end
                    2'd1: begin
                        if (div_rsp.done) begin
                            o_avg_next = q_sat[23:0];
                            phase_next = 2'd2;
                            div_req.start = 1'b1;
                            if (accept_reg > 1) begin
                                div_req.num = {32'd0, adiff_reg}
                                              + 64'((accept_reg - 1'b1) >> 1);
                                div_req.den = 32'(accept_reg - 1'b1);
                            end else begin
                                div_req.num = '0;
                                div_req.den = 32'd1;
                            end
                        end
                    end
                    2'd2: begin
                        if (div_rsp.done) begin
                            o_jit_next    = q_sat[23:0];
                            phase_next    = 2'd3;
                            div_req.start = 1'b1;
                            div_req.num   = 64'(lost) * 64'd10000 + 64'(expect_reg >> 1);
                            div_req.den   = 32'(expect_reg);
                        end
                    end
                    default: begin
                        if (div_rsp.done && accept_reg != '0 && expect_reg != '0) begin
                            o_loss_next = (q_sat > 64'd10000) ? 14'd10000 : q_sat[13:0];
                        end
                    end
                endcase
            end
            S_COMPACT: begin
                if (rd_idx_reg >= count_reg) begin
                    count_next = wr_idx_reg;
                end else begin
                    mem_ctl.rd_en   = 1'b1;
                    mem_ctl.rd_addr = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next     = rd_idx_reg + 1'b1;
                end
            end
            S_COMPACT_CHK: begin
                if (rd_dst != target_reg) begin
                    mem_ctl.wr_en   = 1'b1;
                    mem_ctl.wr_addr = wr_idx_reg[IDX_W-1:0];
                    mem_ctl.wr_seq  = rd_seq;
                    mem_ctl.wr_dst  = rd_dst;
                    wr_idx_next     = wr_idx_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            phase_reg    <= 2'd0;
            count_reg    <= '0;
            target_reg   <= '0;
            expect_reg   <= '0;
            accept_reg   <= '0;
            total_reg    <= '0;
            adiff_reg    <= '0;
            prev_rtt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            target_reg   <= target_next;
            expect_reg   <= expect_next;
            accept_reg   <= accept_next;
            total_reg    <= total_next;
            adiff_reg    <= adiff_next;
            prev_rtt_reg <= prev_rtt_next;
        end
        seq_reg       <= seq_next;
        diff_sec_reg  <= diff_sec_next;
        diff_usec_reg <= diff_usec_next;
        rtt_reg       <= rtt_next;
        rd_idx_reg    <= rd_idx_next;
        wr_idx_reg    <= wr_idx_next;
        o_status_reg  <= o_status_next;
        o_sample_reg  <= o_sample_next;
        o_avg_reg     <= o_avg_next;
        o_jit_reg     <= o_jit_next;
        o_loss_reg    <= o_loss_next;
    end

    always_comb begin
        s_ready          = (state_reg == S_IDLE);
        m_valid          = (state_reg == S_OUT);
        m_status         = o_status_reg;
        m_sample_rtt_us  = o_sample_reg;
        m_avg_rtt_us     = o_avg_reg;
        m_jitter_us      = o_jit_reg;
        m_loss_centipct  = o_loss_reg;
        m_received_count = 8'(accept_reg);
        m_expected_count = 8'(expect_reg);
    end
endmodule

### rtl/probe_echo_rtt_jitter_loss.sv
// Channel  | Ports            | Direction | Transaction
// input    | s_valid/s_ready  | in        | one probe item (record, begin, response, finish)
// result   | m_valid/m_ready  | out       | one status item per input item
// config   | cfg_valid/ready  | in        | write of the RTT limit
//
// Record and begin go straight to the result, which then waits for the output handshake.
// A response walks the table one entry at a time, reading an entry and then checking it.
// A finish runs up to three 64-step divisions, then compacts the table one entry at a time
// through the single read port of the table memory.
// Reset is synchronous and active low; the table needs no clearing pass.
// A stalled result holds the block; no new input item is taken until it leaves.
module probe_echo_rtt_jitter_loss (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_seq_number,
    input  logic [31:0] s_dest_addr,
    input  logic [31:0] s_sent_sec,
    input  logic [19:0] s_sent_usec,
    input  logic [31:0] s_recv_sec,
    input  logic [19:0] s_recv_usec,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [23:0] m_sample_rtt_us,
    output logic [23:0] m_avg_rtt_us,
    output logic [23:0] m_jitter_us,
    output logic [13:0] m_loss_centipct,
    output logic [7:0]  m_received_count,
    output logic [7:0]  m_expected_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data
);
    import perjl_pkg::*;

    logic [23:0] limit_reg;
    mem_ctl_t    mem_ctl;
    logic [31:0] rd_seq, rd_dst;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= RTT_LIMIT_RESET;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    perjl_table u_table (
        .aclk   (aclk),
        .ctl    (mem_ctl),
        .rd_seq (rd_seq),
        .rd_dst (rd_dst)
    );

    perjl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    perjl_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_seq_number     (s_seq_number),
        .s_dest_addr      (s_dest_addr),
        .s_sent_sec       (s_sent_sec),
        .s_sent_usec      (s_sent_usec),
        .s_recv_sec       (s_recv_sec),
        .s_recv_usec      (s_recv_usec),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_sample_rtt_us  (m_sample_rtt_us),
        .m_avg_rtt_us     (m_avg_rtt_us),
        .m_jitter_us      (m_jitter_us),
        .m_loss_centipct  (m_loss_centipct),
        .m_received_count (m_received_count),
        .m_expected_count (m_expected_count),
        .rtt_limit        (limit_reg),
        .mem_ctl          (mem_ctl),
        .rd_seq           (rd_seq),
        .rd_dst           (rd_dst),
        .div_req          (div_req),
        .div_rsp          (div_rsp)
    );
endmodule

### rtl/perjl_checker.sv
module perjl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [23:0] m_sample_rtt_us,
    input logic [13:0] m_loss_centipct,
    input logic [7:0]  m_received_count,
    input logic [7:0]  m_expected_count
);
    import perjl_pkg::*;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("Result changed while stalled.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("Input taken while a result is pending.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_COMPLETE && m_loss_centipct <= 14'd10000)
        else $error("Result field out of range.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_sample_rtt_us == 24'd0)
        else $error("Sample reported for a rejected transaction.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_received_count <= m_expected_count)
        else $error("More responses accepted than expected.");
endmodule

bind probe_echo_rtt_jitter_loss perjl_checker u_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_sample_rtt_us  (m_sample_rtt_us),
    .m_loss_centipct  (m_loss_centipct),
    .m_received_count (m_received_count),
    .m_expected_count (m_expected_count)
);
